[rtl/life_like_range_rule_cell_core_macros.svh]
// Assertion macros shared by the cell-check RTL.
`ifndef LIFE_LIKE_RANGE_RULE_CELL_CORE_MACROS_SVH
`define LIFE_LIKE_RANGE_RULE_CELL_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LLR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define LLR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/llr_pkg.sv]
// Shared types and constants for the range-rule cell check.
`timescale 1ns / 1ps
`default_nettype none

package llr_pkg;

	localparam int RAD_W   = 3;
	localparam int STEP_W  = 4;
	localparam int CNT_W   = 8;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam logic [CNT_W-1:0] MAX_COUNT = 8'd224;

	// Register map, by word index
	typedef enum logic [2:0] {
		REG_RADIUS    = 3'd0,
		REG_BIRTH_LO  = 3'd1,
		REG_BIRTH_HI  = 3'd2,
		REG_SURV_LO   = 3'd3,
		REG_SURV_HI   = 3'd4
	} reg_idx_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	// One cell access moving down the address/read pipeline
	typedef struct packed {
		logic valid;
		logic we;
		logic wdata;
		logic first;
		logic center;
		logic last;
	} walk_tok_t;

	// Evaluator status back to the walker
	typedef struct packed {
		logic done;
		logic pend;
	} eval_stat_t;

	// Rule thresholds
	typedef struct packed {
		logic [CNT_W-1:0] birth_low;
		logic [CNT_W-1:0] birth_high;
		logic [CNT_W-1:0] survive_low;
		logic [CNT_W-1:0] survive_high;
	} rule_cfg_t;

endpackage

`default_nettype wire

[rtl/llr_walk.sv]
// Sequencer: coordinate reduction, window walk and cell address generation.
`timescale 1ns / 1ps
`default_nettype none
`include "life_like_range_rule_cell_core_macros.svh"

module llr_walk #(
	parameter int BOARD_WIDTH  = 256,
	parameter int BOARD_HEIGHT = 256,
	parameter int MAX_RADIUS   = 7,
	parameter int ADDR_W       = 17
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        opcode,
	input  wire logic                        plane,
	input  wire logic [7:0]                  col,
	input  wire logic [7:0]                  row,
	input  wire logic                        cell_value,
	input  wire logic [llr_pkg::RAD_W-1:0]   window_radius,
	input  wire llr_pkg::eval_stat_t         stat,
	output llr_pkg::walk_tok_t               tok_s1,
	output logic [ADDR_W-1:0]                addr_s1
);
	import llr_pkg::*;

	localparam int CW  = $clog2(BOARD_WIDTH);
	localparam int RW  = $clog2(BOARD_HEIGHT);
	localparam int CAW = (CW > 8) ? CW : 8;
	localparam int RAW = (RW > 8) ? RW : 8;
	localparam int PLANE_CELLS = BOARD_WIDTH * BOARD_HEIGHT;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_PUT,
		ST_WALK,
		ST_WAIT
	} state_t;

	state_t state_q;

	logic              op_q;
	logic              plane_q;
	logic              value_q;
	logic [CAW-1:0]    c_q;
	logic [RAW-1:0]    r_q;
	logic [RAD_W-1:0]  rad_q;
	logic [CW-1:0]     cc_q;
	logic [RW-1:0]     rr_q;
	logic [RW-1:0]     rr_start_q;
	logic [STEP_W-1:0] dc_q;
	logic [STEP_W-1:0] dr_q;

	logic              accept;
	logic [RAD_W-1:0]  rad_in;
	logic              c_hi;
	logic              r_hi;
	logic              reduced;
	logic [CW-1:0]     c_red;
	logic [RW-1:0]     r_red;
	logic [CW:0]       c_sum;
	logic [RW:0]       r_sum;
	logic [CW-1:0]     cc_start;
	logic [RW-1:0]     rr_start;
	logic [CW-1:0]     cc_inc;
	logic [RW-1:0]     rr_inc;
	logic [STEP_W-1:0] two_rad;
	logic              row_end;
	walk_tok_t         tok_d;

	assign accept  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !stat.pend;
	assign rad_in  = (window_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : window_radius;

	// Modulo reduction: one compare/subtract per cycle on each coordinate
	assign c_hi    = {1'b0, c_q} >= (CAW + 1)'(BOARD_WIDTH);
	assign r_hi    = {1'b0, r_q} >= (RAW + 1)'(BOARD_HEIGHT);
	assign reduced = !c_hi && !r_hi;
	assign c_red   = c_q[CW-1:0];
	assign r_red   = r_q[RW-1:0];

	// Window corner: coordinate minus radius, wrapped
	always_comb begin
		c_sum = (CW + 1)'(c_red) + (CW + 1)'(BOARD_WIDTH) - (CW + 1)'(rad_q);
		r_sum = (RW + 1)'(r_red) + (RW + 1)'(BOARD_HEIGHT) - (RW + 1)'(rad_q);
		cc_start = (c_sum >= (CW + 1)'(BOARD_WIDTH)) ?
			CW'(c_sum - (CW + 1)'(BOARD_WIDTH)) : CW'(c_sum);
		rr_start = (r_sum >= (RW + 1)'(BOARD_HEIGHT)) ?
			RW'(r_sum - (RW + 1)'(BOARD_HEIGHT)) : RW'(r_sum);
	end

	// Wrapping steps along the window
	assign cc_inc  = (cc_q == CW'(BOARD_WIDTH - 1)) ? '0 : cc_q + 1'b1;
	assign rr_inc  = (rr_q == RW'(BOARD_HEIGHT - 1)) ? '0 : rr_q + 1'b1;
	assign two_rad = {rad_q, 1'b0};
	assign row_end = (dr_q == two_rad);

	// Token for the cell addressed this cycle
	always_comb begin
		tok_d.valid  = (state_q == ST_WALK) || (state_q == ST_PUT);
		tok_d.we     = (state_q == ST_PUT);
		tok_d.wdata  = value_q;
		tok_d.first  = (dc_q == '0) && (dr_q == '0);
		tok_d.center = (dc_q == STEP_W'(rad_q)) && (dr_q == STEP_W'(rad_q));
		tok_d.last   = (dc_q == two_rad) && row_end;
	end

	// Sequencer state and token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tok_s1  <= '0;
		end else begin
			tok_s1 <= tok_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (reduced) begin
						state_q <= (op_q == OP_WRITE) ? ST_PUT : ST_WALK;
					end
				end
				ST_PUT: begin
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (tok_d.last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (stat.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Coordinates, counters and address
	always_ff @(posedge clk) begin
		addr_s1 <= (plane_q ? ADDR_W'(PLANE_CELLS) : '0)
			+ ADDR_W'(cc_q) * ADDR_W'(BOARD_HEIGHT) + ADDR_W'(rr_q);
		if (accept) begin
			op_q    <= opcode;
			plane_q <= plane;
			value_q <= cell_value;
			c_q     <= CAW'(col);
			r_q     <= RAW'(row);
			rad_q   <= rad_in;
		end
		if (state_q == ST_REDUCE) begin
			if (c_hi) begin
				c_q <= c_q - CAW'(BOARD_WIDTH);
			end
			if (r_hi) begin
				r_q <= r_q - RAW'(BOARD_HEIGHT);
			end
			if (reduced) begin
				dc_q <= '0;
				dr_q <= '0;
				if (op_q == OP_WRITE) begin
					cc_q <= c_red;
					rr_q <= r_red;
				end else begin
					cc_q       <= cc_start;
					rr_q       <= rr_start;
					rr_start_q <= rr_start;
				end
			end
		end
		if (state_q == ST_WALK) begin
			if (row_end) begin
				dr_q <= '0;
				dc_q <= dc_q + 1'b1;
				rr_q <= rr_start_q;
				cc_q <= cc_inc;
			end else begin
				dr_q <= dr_q + 1'b1;
				rr_q <= rr_inc;
			end
		end
	end

	// Checks
	`LLR_ASSERT_NXT(a_accept_reduce, accept, state_q == ST_REDUCE, "accepted item did not start")
	`LLR_ASSERT_IMP(a_walk_bound, state_q == ST_WALK, (dc_q <= two_rad) && (dr_q <= two_rad), "window step out of range")
	`LLR_ASSERT_IMP(a_no_start_pending, accept, !stat.pend && (state_q == ST_IDLE), "item taken while busy")

endmodule

`default_nettype wire

[rtl/llr_mem.sv]
// Two-plane cell store, one access per cycle, registered read.
`timescale 1ns / 1ps
`default_nettype none

module llr_mem #(
	parameter int DEPTH  = 131072,
	parameter int ADDR_W = 17
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire llr_pkg::walk_tok_t tok_s1,
	input  wire logic [ADDR_W-1:0]  addr_s1,
	output llr_pkg::walk_tok_t      tok_s2,
	output logic                    rdata_s2
);
	import llr_pkg::*;

	logic cells_q [DEPTH];

	walk_tok_t tok_rd;

	// Single port: write on a write token; the addressed cell is read every cycle
	always_ff @(posedge clk) begin
		if (tok_s1.valid && tok_s1.we) begin
			cells_q[addr_s1] <= tok_s1.wdata;
		end
		rdata_s2 <= cells_q[addr_s1];
	end

	// Only read tokens continue to the evaluator
	always_comb begin
		tok_rd       = tok_s1;
		tok_rd.valid = tok_s1.valid && !tok_s1.we;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
		end else begin
			tok_s2 <= tok_rd;
		end
	end

endmodule

`default_nettype wire

[rtl/llr_eval.sv]
// Neighbor accumulation, range rule and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "life_like_range_rule_cell_core_macros.svh"

module llr_eval (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire llr_pkg::walk_tok_t        tok_s2,
	input  wire logic                      rdata_s2,
	input  wire llr_pkg::rule_cfg_t        rule,
	output llr_pkg::eval_stat_t            stat,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           alive_next,
	output logic [llr_pkg::CNT_W-1:0]      neighbour_count
);
	import llr_pkg::*;

	logic             cnt_q;
	logic [CNT_W-1:0] acc_q;
	logic             live_q;
	logic             pend_q;
	logic             pend_alive_q;
	logic [CNT_W-1:0] pend_cnt_q;
	logic             out_valid_q;
	logic             alive_q;
	logic [CNT_W-1:0] count_q;

	logic [CNT_W-1:0] acc_nx;
	logic             live_nx;
	logic             next_alive;
	logic             done;
	logic             move;

	// Running count; the center only records liveness
	always_comb begin
		acc_nx  = (tok_s2.first ? '0 : acc_q) + CNT_W'(!tok_s2.center && rdata_s2);
		live_nx = tok_s2.center ? rdata_s2 : live_q;
		next_alive = ((acc_nx >= rule.birth_low) && (acc_nx <= rule.birth_high))
			|| (live_nx && (acc_nx >= rule.survive_low) && (acc_nx <= rule.survive_high));
	end

	assign done = tok_s2.valid && tok_s2.last;
	assign move = pend_q && (!out_valid_q || out_ready);
	assign cnt_q = 1'b0;

	assign stat.done       = done;
	assign stat.pend       = pend_q || cnt_q;
	assign out_valid       = out_valid_q;
	assign alive_next      = alive_q;
	assign neighbour_count = count_q;

	// Handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end
			if (done) begin
				pend_q <= 1'b1;
			end
		end
	end

	// Accumulator and result payload
	always_ff @(posedge clk) begin
		if (tok_s2.valid) begin
			acc_q  <= acc_nx;
			live_q <= live_nx;
		end
		if (done) begin
			pend_cnt_q   <= acc_nx;
			pend_alive_q <= next_alive;
		end
		if (move) begin
			count_q <= pend_cnt_q;
			alive_q <= pend_alive_q;
		end
	end

	// Checks
	`LLR_ASSERT_IMP(a_no_token_pending, pend_q, !tok_s2.valid, "cell read arrived while result pending")
	`LLR_ASSERT_IMP(a_count_bound, out_valid_q, count_q <= MAX_COUNT, "neighbor count out of range")
	`LLR_ASSERT_NXT(a_done_pends, done, pend_q || out_valid_q, "finished check was lost")

endmodule

`default_nettype wire

[rtl/life_like_range_rule_cell_core.sv]
// Top level: register port, sequencer, cell store and rule evaluator.
`timescale 1ns / 1ps
`default_nettype none

// Larger-than-life cell check over two wrapping one-bit boards. A write item
// stores one cell and returns nothing; a check item returns the live count in
// the square window of the programmed radius (center excluded) and the
// next-alive flag from the birth and survival ranges. One window cell is read
// from the single-port cell store per cycle; the window is 2R+1 cells on a
// side, with R the radius after limiting to MAX_RADIUS. Coordinates at or
// above the board size are brought into range by subtracting the size. No
// item is taken while one is in progress or while a finished result waits
// behind the output register. The store is not cleared at reset: load a
// plane before checking cells in it.
module life_like_range_rule_cell_core #(
	parameter int BOARD_WIDTH  = 256,
	parameter int BOARD_HEIGHT = 256,
	parameter int MAX_RADIUS   = 7
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [llr_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [llr_pkg::PDATA_W-1:0]   pwdata,
	output logic [llr_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          opcode,
	input  wire logic                          plane,
	input  wire logic [7:0]                    col,
	input  wire logic [7:0]                    row,
	input  wire logic                          cell_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               alive_next,
	output logic [llr_pkg::CNT_W-1:0]          neighbour_count
);
	import llr_pkg::*;

	localparam int DEPTH  = 2 * BOARD_WIDTH * BOARD_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [RAD_W-1:0] radius_q;
	logic [CNT_W-1:0] birth_low_q;
	logic [CNT_W-1:0] birth_high_q;
	logic [CNT_W-1:0] survive_low_q;
	logic [CNT_W-1:0] survive_high_q;

	reg_idx_t          reg_idx;
	logic              reg_wr;
	rule_cfg_t         rule;
	eval_stat_t        stat;
	walk_tok_t         tok_s1;
	walk_tok_t         tok_s2;
	logic [ADDR_W-1:0] addr_s1;
	logic              rdata_s2;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign reg_wr  = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q       <= 3'd1;
			birth_low_q    <= 8'd3;
			birth_high_q   <= 8'd3;
			survive_low_q  <= 8'd2;
			survive_high_q <= 8'd3;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_RADIUS:   radius_q       <= pwdata[RAD_W-1:0];
				REG_BIRTH_LO: birth_low_q    <= pwdata[CNT_W-1:0];
				REG_BIRTH_HI: birth_high_q   <= pwdata[CNT_W-1:0];
				REG_SURV_LO:  survive_low_q  <= pwdata[CNT_W-1:0];
				REG_SURV_HI:  survive_high_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (reg_idx)
			REG_RADIUS:   prdata = PDATA_W'(radius_q);
			REG_BIRTH_LO: prdata = PDATA_W'(birth_low_q);
			REG_BIRTH_HI: prdata = PDATA_W'(birth_high_q);
			REG_SURV_LO:  prdata = PDATA_W'(survive_low_q);
			REG_SURV_HI:  prdata = PDATA_W'(survive_high_q);
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		rule.birth_low    = birth_low_q;
		rule.birth_high   = birth_high_q;
		rule.survive_low  = survive_low_q;
		rule.survive_high = survive_high_q;
	end

	llr_walk #(
		.BOARD_WIDTH  (BOARD_WIDTH),
		.BOARD_HEIGHT (BOARD_HEIGHT),
		.MAX_RADIUS   (MAX_RADIUS),
		.ADDR_W       (ADDR_W)
	) u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.plane         (plane),
		.col           (col),
		.row           (row),
		.cell_value    (cell_value),
		.window_radius (radius_q),
		.stat          (stat),
		.tok_s1        (tok_s1),
		.addr_s1       (addr_s1)
	);

	llr_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_s1   (tok_s1),
		.addr_s1  (addr_s1),
		.tok_s2   (tok_s2),
		.rdata_s2 (rdata_s2)
	);

	llr_eval u_eval (
		.clk             (clk),
		.arst_n          (arst_n),
		.tok_s2          (tok_s2),
		.rdata_s2        (rdata_s2),
		.rule            (rule),
		.stat            (stat),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.alive_next      (alive_next),
		.neighbour_count (neighbour_count)
	);

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the range-rule cell check core.
`timescale 1ns / 1ps

module testbench;
	import llr_pkg::*;

	// Loaded board patch: every check window stays inside it
	localparam int         PATCH_SPAN    = 20;
	localparam logic [7:0] PATCH_COL0    = 8'd246;
	localparam logic [7:0] PATCH_ROW0    = 8'd250;
	localparam int         RANDOM_ITEMS  = 1080;
	localparam int         SETTLE_CYCLES = 16;
	localparam int         DRAIN_CYCLES  = 240;
	// Register indexes past the end of the map
	localparam logic [2:0] REG_HOLE_LO   = 3'd5;
	localparam logic [2:0] REG_HOLE_HI   = 3'd7;

	typedef struct packed {
		logic       opcode;
		logic       plane;
		logic [7:0] col;
		logic [7:0] row;
		logic       cell_value;
	} cell_op_t;

	typedef struct packed {
		logic             alive_next;
		logic [CNT_W-1:0] neighbour_count;
	} cell_census_t;

	typedef struct packed {
		logic         is_reg;
		logic [2:0]   reg_sel;
		logic [31:0]  reg_data;
		cell_op_t     op;
		logic         typed;
		cell_census_t want;
	} plan_row_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               psel       = 1'b0;
	logic               penable    = 1'b0;
	logic               pwrite     = 1'b0;
	logic [PADDR_W-1:0] paddr      = '0;
	logic [PDATA_W-1:0] pwdata     = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic               opcode     = 1'b0;
	logic               plane      = 1'b0;
	logic [7:0]         col        = '0;
	logic [7:0]         row        = '0;
	logic               cell_value = 1'b0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic               alive_next;
	logic [CNT_W-1:0]   neighbour_count;

	// Shadow of the board and of the rule registers
	bit         board_img [0:1][0:255][0:255];
	logic [2:0] cfg_radius   = 3'd1;
	logic [7:0] cfg_birth_lo = 8'd3;
	logic [7:0] cfg_birth_hi = 8'd3;
	logic [7:0] cfg_surv_lo  = 8'd2;
	logic [7:0] cfg_surv_hi  = 8'd3;

	cell_census_t census_due[$];
	bit           failed    = 1'b0;
	int           idle_pct  = 0;
	int           stall_pct = 0;

	life_like_range_rule_cell_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.plane           (plane),
		.col             (col),
		.row             (row),
		.cell_value      (cell_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.alive_next      (alive_next),
		.neighbour_count (neighbour_count)
	);

	always #5 clk = ~clk;

	// Watchdog
	initial begin
		#50_000_000;
		$display("life_like_range_rule_cell_core verification failed");
		$finish;
	end

	// Result sink: compare each transaction against the oldest expectation
	always @(posedge clk) begin : sink
		cell_census_t due;
		if (arst_n && out_valid && out_ready) begin
			if (census_due.size() == 0) begin
				$display("%0t: unexpected result alive_next %0b neighbour_count %0d",
					$time, alive_next, neighbour_count);
				failed = 1'b1;
			end else begin
				due = census_due.pop_front();
				if (alive_next !== due.alive_next) begin
					$display("%0t: alive_next expected %0b got %0b",
						$time, due.alive_next, alive_next);
					failed = 1'b1;
				end
				if (neighbour_count !== due.neighbour_count) begin
					$display("%0t: neighbour_count expected %0d got %0d",
						$time, due.neighbour_count, neighbour_count);
					failed = 1'b1;
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Window count around a cell (center left out) and the birth/survival verdict
	function automatic cell_census_t take_census(logic pl, logic [7:0] c, logic [7:0] r);
		cell_census_t res;
		int           n;
		int           rad;
		logic [7:0]   cc;
		logic [7:0]   rr;
		n   = 0;
		rad = cfg_radius;
		for (int dc = -rad; dc <= rad; dc++) begin
			for (int dr = -rad; dr <= rad; dr++) begin
				// 8-bit truncation gives the toroidal wrap on a 256-cell board
				cc = c + dc;
				rr = r + dr;
				if ((dc != 0 || dr != 0) && board_img[pl][cc][rr])
					n++;
			end
		end
		res.neighbour_count = n[7:0];
		res.alive_next = (n >= cfg_birth_lo && n <= cfg_birth_hi) ||
			(board_img[pl][c][r] && n >= cfg_surv_lo && n <= cfg_surv_hi);
		return res;
	endfunction

	function automatic logic [31:0] register_image(logic [2:0] idx);
		case (idx)
			REG_RADIUS:   return {29'd0, cfg_radius};
			REG_BIRTH_LO: return {24'd0, cfg_birth_lo};
			REG_BIRTH_HI: return {24'd0, cfg_birth_hi};
			REG_SURV_LO:  return {24'd0, cfg_surv_lo};
			REG_SURV_HI:  return {24'd0, cfg_surv_hi};
			default:      return '0;
		endcase
	endfunction

	function automatic plan_row_t reg_row(logic [2:0] idx, logic [31:0] data);
		plan_row_t pr;
		pr          = '0;
		pr.is_reg   = 1'b1;
		pr.reg_sel  = idx;
		pr.reg_data = data;
		return pr;
	endfunction

	function automatic plan_row_t op_row(logic opc, logic pl, logic [7:0] c, logic [7:0] r,
			logic v, logic typed, logic alive, logic [7:0] cnt);
		plan_row_t pr;
		pr                      = '0;
		pr.op                   = '{opc, pl, c, r, v};
		pr.typed                = typed;
		pr.want.alive_next      = alive;
		pr.want.neighbour_count = cnt;
		return pr;
	endfunction

	// One APB transaction; setup, access, then idle
	task automatic apb_cycle(input logic wr, input logic [2:0] idx, input logic [31:0] data,
			output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Register write, shadow update, and read-back of mapped registers
	task automatic program_register(input logic [2:0] idx, input logic [31:0] data);
		logic [31:0] got;
		apb_cycle(1'b1, idx, data, got);
		case (idx)
			REG_RADIUS:   cfg_radius   = data[2:0];
			REG_BIRTH_LO: cfg_birth_lo = data[7:0];
			REG_BIRTH_HI: cfg_birth_hi = data[7:0];
			REG_SURV_LO:  cfg_surv_lo  = data[7:0];
			REG_SURV_HI:  cfg_surv_hi  = data[7:0];
			default:      ;
		endcase
		if (idx <= REG_SURV_HI) begin
			apb_cycle(1'b0, idx, 32'd0, got);
			if (got !== register_image(idx)) begin
				$display("%0t: register %0d expected %0h got %0h",
					$time, idx, register_image(idx), got);
				failed = 1'b1;
			end
		end
	endtask

	// Drive one input transaction; predict at acceptance
	task automatic issue_op(input cell_op_t op, input logic typed, input cell_census_t want);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op.opcode;
		plane      <= op.plane;
		col        <= op.col;
		row        <= op.row;
		cell_value <= op.cell_value;
		do @(posedge clk); while (!in_ready);
		if (op.opcode == OP_CHECK)
			census_due.push_back(typed ? want : take_census(op.plane, op.col, op.row));
		else
			board_img[op.plane][op.col][op.row] = op.cell_value;
	endtask

	// Wait until the block is idle: results drained, trailing write retired
	task automatic settle();
		in_valid <= 1'b0;
		while (census_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [31:0] got;
		cell_op_t    op;
		plan_row_t   plan[$];
		int          rad;
		int          span_n;
		int          density;
		int          pick;
		int          lo;
		int          hi;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register reset values
		for (int k = 0; k <= int'(REG_SURV_HI); k++) begin
			apb_cycle(1'b0, k[2:0], 32'd0, got);
			if (got !== register_image(k[2:0])) begin
				$display("%0t: register %0d after reset expected %0h got %0h",
					$time, k, register_image(k[2:0]), got);
				failed = 1'b1;
			end
		end

		// Load the corner patch of both planes: plane 0 random, plane 1 all live
		for (int p = 0; p < 2; p++)
			for (int i = 0; i < PATCH_SPAN; i++)
				for (int j = 0; j < PATCH_SPAN; j++) begin
					op.opcode     = OP_WRITE;
					op.plane      = p[0];
					op.col        = PATCH_COL0 + i[7:0];
					op.row        = PATCH_ROW0 + j[7:0];
					op.cell_value = p[0] ? 1'b1 : 1'(($urandom_range(0, 1)));
					issue_op(op, 1'b0, '0);
				end

		// Directed part; typed expectations lean on the all-live plane 1
		plan.push_back(op_row(OP_CHECK, 1'b1, 8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 8'd8));
		plan.push_back(reg_row(REG_RADIUS, 32'd0));
		plan.push_back(op_row(OP_CHECK, 1'b1, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0, 8'd0));
		plan.push_back(reg_row(REG_SURV_LO, 32'd0));
		plan.push_back(op_row(OP_CHECK, 1'b1, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1, 8'd0));
		plan.push_back(op_row(OP_CHECK, 1'b0, 8'd9,   8'd13,  1'b1, 1'b0, 1'b0, 8'd0));
		plan.push_back(reg_row(REG_RADIUS, 32'd7));
		plan.push_back(op_row(OP_CHECK, 1'b1, 8'd0,   8'd3,   1'b0, 1'b1, 1'b0, 8'd224));
		plan.push_back(reg_row(REG_BIRTH_LO, 32'd0));
		plan.push_back(reg_row(REG_BIRTH_HI, 32'd255));
		plan.push_back(op_row(OP_CHECK, 1'b1, 8'd255, 8'd1,   1'b0, 1'b1, 1'b1, 8'd224));
		// birth range emptied: low above high
		plan.push_back(reg_row(REG_BIRTH_LO, 32'd255));
		plan.push_back(reg_row(REG_BIRTH_HI, 32'd0));
		plan.push_back(reg_row(REG_SURV_LO, 32'd224));
		plan.push_back(reg_row(REG_SURV_HI, 32'd224));
		plan.push_back(op_row(OP_CHECK, 1'b1, 8'd2,   8'd6,   1'b1, 1'b1, 1'b1, 8'd224));
		plan.push_back(op_row(OP_WRITE, 1'b1, 8'd0,   8'd3,   1'b0, 1'b0, 1'b0, 8'd0));
		plan.push_back(op_row(OP_CHECK, 1'b1, 8'd0,   8'd3,   1'b0, 1'b1, 1'b0, 8'd224));
		plan.push_back(op_row(OP_CHECK, 1'b1, 8'd1,   8'd3,   1'b0, 1'b1, 1'b0, 8'd223));
		plan.push_back(reg_row(REG_SURV_LO, 32'd0));
		plan.push_back(reg_row(REG_SURV_HI, 32'd255));
		plan.push_back(op_row(OP_CHECK, 1'b1, 8'd1,   8'd4,   1'b1, 1'b1, 1'b1, 8'd223));
		plan.push_back(op_row(OP_WRITE, 1'b0, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0, 8'd0));
		plan.push_back(op_row(OP_WRITE, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0));
		plan.push_back(op_row(OP_WRITE, 1'b0, 8'd127, 8'd128, 1'b1, 1'b0, 1'b0, 8'd0));
		plan.push_back(op_row(OP_CHECK, 1'b0, 8'd0,   8'd3,   1'b0, 1'b0, 1'b0, 8'd0));
		plan.push_back(op_row(OP_CHECK, 1'b0, 8'd253, 8'd6,   1'b1, 1'b0, 1'b0, 8'd0));
		// writes off the register map must leave the rule alone; a radius write keeps only its low bits
		plan.push_back(reg_row(REG_HOLE_LO, 32'hFFFF_FFFF));
		plan.push_back(reg_row(REG_HOLE_HI, 32'hFFFF_FFFF));
		plan.push_back(reg_row(REG_RADIUS, 32'hFFFF_FFFB));
		plan.push_back(op_row(OP_CHECK, 1'b0, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 8'd0));
		plan.push_back(op_row(OP_CHECK, 1'b0, 8'd6,   8'd10,  1'b1, 1'b0, 1'b0, 8'd0));

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				program_register(plan[i].reg_sel, plan[i].reg_data);
			end else begin
				issue_op(plan[i].op, plan[i].typed, plan[i].want);
			end
		end

		// Random part: one radius per sub-phase, random rule ranges and cell density
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			for (int s = 0; s < 2; s++) begin
				rad    = 2 * ph + s;
				span_n = (2 * rad + 1) * (2 * rad + 1) - 1;
				settle();
				program_register(REG_RADIUS, ($urandom & ~32'h7) | rad);
				for (int k = 0; k < 2; k++) begin
					lo = $urandom_range(0, span_n);
					hi = lo + $urandom_range(0, span_n / 2 + 1);
					if (hi > 255)
						hi = 255;
					// now and then an empty range
					if ($urandom_range(0, 7) == 0) begin
						pick = lo;
						lo   = (hi < 255) ? hi + 1 : 255;
						hi   = pick;
					end
					program_register(k ? REG_SURV_LO : REG_BIRTH_LO, ($urandom & ~32'hFF) | lo);
					program_register(k ? REG_SURV_HI : REG_BIRTH_HI, ($urandom & ~32'hFF) | hi);
				end

				density = $urandom_range(10, 90);
				for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
					pick          = $urandom_range(0, 99);
					op.plane      = 1'($urandom_range(0, 1));
					op.cell_value = ($urandom_range(0, 99) < density);
					if (pick < 55) begin
						// center keeps the whole window inside the loaded patch
						op.opcode = OP_CHECK;
						op.col    = PATCH_COL0 + 8'($urandom_range(rad, PATCH_SPAN - 1 - rad));
						op.row    = PATCH_ROW0 + 8'($urandom_range(rad, PATCH_SPAN - 1 - rad));
					end else if (pick < 90) begin
						op.opcode = OP_WRITE;
						op.col    = PATCH_COL0 + 8'($urandom_range(0, PATCH_SPAN - 1));
						op.row    = PATCH_ROW0 + 8'($urandom_range(0, PATCH_SPAN - 1));
					end else begin
						// write anywhere on the board
						op.opcode = OP_WRITE;
						op.col    = 8'($urandom_range(0, 255));
						op.row    = 8'($urandom_range(0, 255));
					end
					issue_op(op, 1'b0, '0);
				end
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("life_like_range_rule_cell_core verification clean");
		else
			$display("life_like_range_rule_cell_core verification failed");
		$finish;
	end

endmodule

[life_like_range_rule_cell_core.f]
+incdir+rtl
rtl/llr_pkg.sv
rtl/llr_walk.sv
rtl/llr_mem.sv
rtl/llr_eval.sv
rtl/life_like_range_rule_cell_core.sv
verif/testbench.sv
